[rtl/mcv_pkg.sv]
// ----------------------------------------------------------------------------
// mcv_pkg
// Shared types, constants and helpers of the multichannel valid convolution.
// ----------------------------------------------------------------------------
package mcv_pkg;

    localparam int DEF_MAX_WIDTH    = 64;
    localparam int DEF_MAX_CHANNELS = 4;
    localparam int DEF_MAX_KERNEL   = 5;
    localparam int DEF_MAX_FILTERS  = 8;

    // command field widths, sized for the largest supported parameters
    localparam int CMD_COL_W  = 10;
    localparam int CMD_CH_W   = 4;
    localparam int CMD_SLOT_W = 4;

    localparam int CMD_DEPTH = 4;
    localparam int RES_DEPTH = 2;

    localparam int ADDR_W = 5;

    localparam logic OP_WEIGHT = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    typedef enum logic [2:0] {
        REG_IMAGE_HEIGHT  = 3'd0,
        REG_IMAGE_WIDTH   = 3'd1,
        REG_CHANNEL_COUNT = 3'd2,
        REG_KERNEL_HEIGHT = 3'd3,
        REG_KERNEL_WIDTH  = 3'd4,
        REG_FILTER_COUNT  = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic               opcode;
        logic [2:0]         weight_filter;
        logic [2:0]         weight_row;
        logic [2:0]         weight_col;
        logic [1:0]         weight_channel;
        logic signed [15:0] value;
    } t_in_item;

    typedef struct packed {
        logic [2:0]         filter_index;
        logic [7:0]         out_row;
        logic [5:0]         out_col;
        logic signed [39:0] sum;
        logic               last;
    } t_result;

    typedef struct packed {
        logic [2:0] nch;
        logic [2:0] kh;
        logic [2:0] kw;
        logic [3:0] nf;
    } t_geom;

    typedef struct packed {
        logic                  is_sample;
        logic                  wr_ok;
        logic                  compute;
        logic signed [15:0]    value;
        logic [2:0]            wf;
        logic [2:0]            wr;
        logic [2:0]            wc;
        logic [1:0]            wch;
        logic [CMD_SLOT_W-1:0] slot;
        logic [CMD_COL_W-1:0]  col;
        logic [CMD_CH_W-1:0]   ch;
        logic [CMD_SLOT_W-1:0] top_slot;
        logic [7:0]            top;
        logic [CMD_COL_W-1:0]  left;
    } t_cmd;

    function automatic int sat_cfg(int v, int hi);
        if (v < 1) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

endpackage

[rtl/mcv_queue.sv]
// ----------------------------------------------------------------------------
// mcv_queue
// Small first-in first-out queue of words.
// ----------------------------------------------------------------------------
module mcv_queue import mcv_pkg::*; #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_wdata,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_rdata,
    output logic             o_empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr, r_rd;
    logic [AW:0]      r_cnt;
    logic             w_push, w_pop;

    assign o_full  = (int'(r_cnt) == DEPTH);
    assign o_empty = (r_cnt == '0);
    assign w_push  = i_push & ~o_full;
    assign w_pop   = i_pop & ~o_empty;
    assign o_rdata = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (int'(r_wr) + 1 == DEPTH) ? '0 : r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= (int'(r_rd) + 1 == DEPTH) ? '0 : r_rd + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

[rtl/mcv_front.sv]
// ----------------------------------------------------------------------------
// mcv_front
// Register file and raster tracking; turns each word into a store command and flags samples that close a window.
// ----------------------------------------------------------------------------
module mcv_front import mcv_pkg::*; #(
    parameter int MAX_WIDTH    = DEF_MAX_WIDTH,
    parameter int MAX_CHANNELS = DEF_MAX_CHANNELS,
    parameter int MAX_KERNEL   = DEF_MAX_KERNEL,
    parameter int MAX_FILTERS  = DEF_MAX_FILTERS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_in_item          i_item,
    input  logic              i_push,
    input  logic              i_cmd_full,
    output t_cmd              o_cmd,
    output logic              o_cmd_push,
    input  logic              i_psel,
    input  logic              i_penable,
    input  logic              i_pwrite,
    input  logic [ADDR_W-1:0] i_paddr,
    input  logic [31:0]       i_pwdata,
    output logic [31:0]       o_prdata,
    output t_geom             o_geom
);
    localparam int CW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int CHW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int SW  = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;

    logic [7:0]     r_image_height;
    logic [6:0]     r_image_width;
    logic [2:0]     r_channel_count;
    logic [2:0]     r_kernel_height;
    logic [2:0]     r_kernel_width;
    logic [3:0]     r_filter_count;

    logic [7:0]     r_row;
    logic [CW-1:0]  r_col;
    logic [CHW-1:0] r_ch;
    logic [SW-1:0]  r_slot;

    logic [7:0]     w_h;
    logic [6:0]     w_w;
    logic           w_cfg_wr, w_acc, w_last_ch, w_last_col, w_last_row, w_compute;
    t_reg_idx       w_idx;
    int             w_ts;

    assign w_cfg_wr = i_psel & i_penable & i_pwrite;
    assign w_idx    = t_reg_idx'(i_paddr[4:2]);
    assign w_acc    = i_push & ~i_cmd_full;

    assign w_h        = 8'(sat_cfg(int'(r_image_height), 255));
    assign w_w        = 7'(sat_cfg(int'(r_image_width), MAX_WIDTH));
    assign o_geom.nch = 3'(sat_cfg(int'(r_channel_count), MAX_CHANNELS));
    assign o_geom.kh  = 3'(sat_cfg(int'(r_kernel_height), MAX_KERNEL));
    assign o_geom.kw  = 3'(sat_cfg(int'(r_kernel_width), MAX_KERNEL));
    assign o_geom.nf  = 4'(sat_cfg(int'(r_filter_count), MAX_FILTERS));

    assign w_last_ch  = int'(r_ch) + 1 >= int'(o_geom.nch);
    assign w_last_col = int'(r_col) + 1 >= int'(w_w);
    assign w_last_row = int'(r_row) + 1 >= int'(w_h);
    assign w_compute  = w_last_ch && (int'(r_row) + 1 >= int'(o_geom.kh))
                        && (int'(r_col) + 1 >= int'(o_geom.kw));

    always_comb begin
        w_ts = int'(r_slot) + MAX_KERNEL - (int'(o_geom.kh) - 1);
        if (w_ts >= MAX_KERNEL) begin
            w_ts = w_ts - MAX_KERNEL;
        end
    end

    always_comb begin
        o_cmd.is_sample = (i_item.opcode == OP_SAMPLE);
        o_cmd.wr_ok     = (int'(i_item.weight_filter) < MAX_FILTERS)
                          && (int'(i_item.weight_row) < MAX_KERNEL)
                          && (int'(i_item.weight_col) < MAX_KERNEL)
                          && (int'(i_item.weight_channel) < MAX_CHANNELS);
        o_cmd.compute   = w_compute;
        o_cmd.value     = i_item.value;
        o_cmd.wf        = i_item.weight_filter;
        o_cmd.wr        = i_item.weight_row;
        o_cmd.wc        = i_item.weight_col;
        o_cmd.wch       = i_item.weight_channel;
        o_cmd.slot      = CMD_SLOT_W'(r_slot);
        o_cmd.col       = CMD_COL_W'(r_col);
        o_cmd.ch        = CMD_CH_W'(r_ch);
        o_cmd.top_slot  = CMD_SLOT_W'(w_ts);
        o_cmd.top       = 8'(int'(r_row) + 1 - int'(o_geom.kh));
        o_cmd.left      = CMD_COL_W'(int'(r_col) + 1 - int'(o_geom.kw));
    end

    assign o_cmd_push = w_acc;

    always_comb begin
        unique case (w_idx)
            REG_IMAGE_HEIGHT:  o_prdata = 32'(r_image_height);
            REG_IMAGE_WIDTH:   o_prdata = 32'(r_image_width);
            REG_CHANNEL_COUNT: o_prdata = 32'(r_channel_count);
            REG_KERNEL_HEIGHT: o_prdata = 32'(r_kernel_height);
            REG_KERNEL_WIDTH:  o_prdata = 32'(r_kernel_width);
            REG_FILTER_COUNT:  o_prdata = 32'(r_filter_count);
            default:           o_prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_height  <= 8'd32;
            r_image_width   <= 7'd32;
            r_channel_count <= 3'd1;
            r_kernel_height <= 3'd5;
            r_kernel_width  <= 3'd5;
            r_filter_count  <= 4'd6;
            r_row           <= '0;
            r_col           <= '0;
            r_ch            <= '0;
            r_slot          <= '0;
        end else if (w_cfg_wr) begin
            unique case (w_idx)
                REG_IMAGE_HEIGHT:  r_image_height  <= i_pwdata[7:0];
                REG_IMAGE_WIDTH:   r_image_width   <= i_pwdata[6:0];
                REG_CHANNEL_COUNT: r_channel_count <= i_pwdata[2:0];
                REG_KERNEL_HEIGHT: r_kernel_height <= i_pwdata[2:0];
                REG_KERNEL_WIDTH:  r_kernel_width  <= i_pwdata[2:0];
                REG_FILTER_COUNT:  r_filter_count  <= i_pwdata[3:0];
                default: ;
            endcase
            if (int'(w_idx) <= int'(REG_FILTER_COUNT)) begin
                r_row  <= '0;
                r_col  <= '0;
                r_ch   <= '0;
                r_slot <= '0;
            end
        end else if (w_acc && i_item.opcode == OP_SAMPLE) begin
            if (w_last_ch) begin
                r_ch <= '0;
                if (w_last_col) begin
                    r_col <= '0;
                    if (w_last_row) begin
                        r_row  <= '0;
                        r_slot <= '0;
                    end else begin
                        r_row  <= r_row + 8'd1;
                        r_slot <= (int'(r_slot) + 1 == MAX_KERNEL) ? '0 : r_slot + 1'b1;
                    end
                end else begin
                    r_col <= r_col + 1'b1;
                end
            end else begin
                r_ch <= r_ch + 1'b1;
            end
        end
    end

endmodule

[rtl/mcv_back.sv]
// ----------------------------------------------------------------------------
// mcv_back
// Weight and row stores plus one shared multiply-accumulate over each window.
// ----------------------------------------------------------------------------
module mcv_back import mcv_pkg::*; #(
    parameter int MAX_WIDTH    = DEF_MAX_WIDTH,
    parameter int MAX_CHANNELS = DEF_MAX_CHANNELS,
    parameter int MAX_KERNEL   = DEF_MAX_KERNEL,
    parameter int MAX_FILTERS  = DEF_MAX_FILTERS
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cmd    i_cmd,
    input  logic    i_cmd_empty,
    output logic    o_cmd_pop,
    input  t_geom   i_geom,
    output t_result o_res,
    output logic    o_res_push,
    input  logic    i_res_full
);
    localparam int CW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int CHW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int SW  = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
    localparam int FW  = (MAX_FILTERS > 1) ? $clog2(MAX_FILTERS) : 1;
    localparam int WA  = FW + 2 * SW + CHW;
    localparam int RA  = SW + CW + CHW;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RUN  = 3'b010,
        S_WAIT = 3'b100
    } t_state;

    logic signed [15:0] r_wmem [2**WA];
    logic signed [15:0] r_rmem [2**RA];

    t_state             r_state;
    logic [FW-1:0]      r_f;
    logic [SW-1:0]      r_r, r_c, r_slot, r_top_slot;
    logic [CHW-1:0]     r_k;
    logic [7:0]         r_top;
    logic [CW-1:0]      r_left;
    logic               r_first;
    logic               r_v1, r_first1, r_end1;
    logic               r_v2, r_first2, r_end2;
    logic signed [15:0] r_wdat, r_rdat;
    logic signed [31:0] r_prod;
    logic signed [39:0] r_acc;
    logic               r_acc_ok;

    logic               w_issue, w_lk, w_lc, w_lr, w_last_f;
    logic [WA-1:0]      w_waddr_wr, w_waddr_rd;
    logic [RA-1:0]      w_raddr_wr, w_raddr_rd;

    assign o_cmd_pop  = (r_state == S_IDLE) & ~i_cmd_empty;
    assign w_issue    = (r_state == S_RUN);
    assign w_lk       = int'(r_k) + 1 >= int'(i_geom.nch);
    assign w_lc       = int'(r_c) + 1 >= int'(i_geom.kw);
    assign w_lr       = int'(r_r) + 1 >= int'(i_geom.kh);
    assign w_last_f   = int'(r_f) + 1 >= int'(i_geom.nf);

    assign w_waddr_wr = {FW'(i_cmd.wf), SW'(i_cmd.wr), SW'(i_cmd.wc), CHW'(i_cmd.wch)};
    assign w_raddr_wr = {SW'(i_cmd.slot), CW'(i_cmd.col), CHW'(i_cmd.ch)};
    assign w_waddr_rd = {r_f, r_r, r_c, r_k};
    assign w_raddr_rd = {r_slot, CW'(r_left + CW'(r_c)), r_k};

    assign o_res.filter_index = 3'(r_f);
    assign o_res.out_row      = r_top;
    assign o_res.out_col      = 6'(r_left);
    assign o_res.sum          = r_acc;
    assign o_res.last         = w_last_f;
    assign o_res_push         = (r_state == S_WAIT) & r_acc_ok & ~i_res_full;

    always_ff @(posedge i_clk) begin
        if (o_cmd_pop && !i_cmd.is_sample && i_cmd.wr_ok) begin
            r_wmem[w_waddr_wr] <= i_cmd.value;
        end
        if (w_issue) begin
            r_wdat <= r_wmem[w_waddr_rd];
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd_pop && i_cmd.is_sample) begin
            r_rmem[w_raddr_wr] <= i_cmd.value;
        end
        if (w_issue) begin
            r_rdat <= r_rmem[w_raddr_rd];
        end
    end

    always_ff @(posedge i_clk) begin
        r_first1 <= r_first;
        r_end1   <= w_lk & w_lc & w_lr;
        r_prod   <= r_wdat * r_rdat;
        r_first2 <= r_first1;
        r_end2   <= r_end1;
        if (r_v2) begin
            r_acc <= r_first2 ? 40'(r_prod) : r_acc + 40'(r_prod);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_v1     <= 1'b0;
            r_v2     <= 1'b0;
            r_acc_ok <= 1'b0;
            r_first  <= 1'b0;
        end else begin
            r_v1 <= w_issue;
            r_v2 <= r_v1;
            if (r_v2 && r_end2) begin
                r_acc_ok <= 1'b1;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (o_cmd_pop && i_cmd.is_sample && i_cmd.compute) begin
                        r_top_slot <= SW'(i_cmd.top_slot);
                        r_slot     <= SW'(i_cmd.top_slot);
                        r_top      <= i_cmd.top;
                        r_left     <= CW'(i_cmd.left);
                        r_f        <= '0;
                        r_r        <= '0;
                        r_c        <= '0;
                        r_k        <= '0;
                        r_first    <= 1'b1;
                        r_state    <= S_RUN;
                    end
                end
                S_RUN: begin
                    r_first <= 1'b0;
                    if (w_lk) begin
                        r_k <= '0;
                        if (w_lc) begin
                            r_c <= '0;
                            if (w_lr) begin
                                r_state <= S_WAIT;
                            end else begin
                                r_r    <= r_r + 1'b1;
                                r_slot <= (int'(r_slot) + 1 == MAX_KERNEL) ? '0
                                                                          : r_slot + 1'b1;
                            end
                        end else begin
                            r_c <= r_c + 1'b1;
                        end
                    end else begin
                        r_k <= r_k + 1'b1;
                    end
                end
                S_WAIT: begin
                    if (o_res_push) begin
                        r_acc_ok <= 1'b0;
                        if (w_last_f) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_f     <= r_f + 1'b1;
                            r_r     <= '0;
                            r_c     <= '0;
                            r_k     <= '0;
                            r_slot  <= r_top_slot;
                            r_first <= 1'b1;
                            r_state <= S_RUN;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

[rtl/multichannel_conv2d_valid_unit.sv]
// ----------------------------------------------------------------------------
// multichannel_conv2d_valid_unit
// Valid 2D convolution of a multichannel image with a bank of filters.
// ----------------------------------------------------------------------------
//  channel   | handshake            | word
//  ----------+----------------------+----------------------------------------
//  input     | push / full          | i_item   (weight load or image sample)
//  result    | pop / empty          | o_result (one filter sum per word)
//  config    | psel/penable/pwrite  | paddr, pwdata, prdata, pready
//
//  Weight loads and samples that close no window are stored as the back pops them.
//  A sample that closes a window starts the single shared multiply-accumulate,
//  which walks the window once per filter.
//  Reset is synchronous, active low; stores hold garbage until written.
//  A four-word command queue lets input run ahead while the back is busy;
//  a full result queue stalls the back between filters.
// ----------------------------------------------------------------------------
module multichannel_conv2d_valid_unit import mcv_pkg::*; #(
    parameter int MAX_WIDTH    = DEF_MAX_WIDTH,
    parameter int MAX_CHANNELS = DEF_MAX_CHANNELS,
    parameter int MAX_KERNEL   = DEF_MAX_KERNEL,
    parameter int MAX_FILTERS  = DEF_MAX_FILTERS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              push,
    output logic              full,
    input  t_in_item          i_item,
    input  logic              pop,
    output logic              empty,
    output t_result           o_result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);
    t_cmd    w_cmd_in, w_cmd_out;
    logic    w_cmd_push, w_cmd_pop, w_cmd_empty;
    t_geom   w_geom;
    t_result w_res;
    logic    w_res_push, w_res_full;
    logic [$bits(t_result)-1:0] w_res_q;
    logic [$bits(t_cmd)-1:0]    w_cmd_q;

    assign pready = 1'b1;

    mcv_front #(
        .MAX_WIDTH(MAX_WIDTH), .MAX_CHANNELS(MAX_CHANNELS),
        .MAX_KERNEL(MAX_KERNEL), .MAX_FILTERS(MAX_FILTERS)
    ) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_item(i_item), .i_push(push), .i_cmd_full(full),
        .o_cmd(w_cmd_in), .o_cmd_push(w_cmd_push),
        .i_psel(psel), .i_penable(penable), .i_pwrite(pwrite),
        .i_paddr(paddr), .i_pwdata(pwdata), .o_prdata(prdata),
        .o_geom(w_geom)
    );

    mcv_queue #(.WIDTH($bits(t_cmd)), .DEPTH(CMD_DEPTH)) u_cmd_q (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(w_cmd_push), .i_wdata(w_cmd_in), .o_full(full),
        .i_pop(w_cmd_pop), .o_rdata(w_cmd_q), .o_empty(w_cmd_empty)
    );

    assign w_cmd_out = t_cmd'(w_cmd_q);

    mcv_back #(
        .MAX_WIDTH(MAX_WIDTH), .MAX_CHANNELS(MAX_CHANNELS),
        .MAX_KERNEL(MAX_KERNEL), .MAX_FILTERS(MAX_FILTERS)
    ) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cmd(w_cmd_out), .i_cmd_empty(w_cmd_empty), .o_cmd_pop(w_cmd_pop),
        .i_geom(w_geom),
        .o_res(w_res), .o_res_push(w_res_push), .i_res_full(w_res_full)
    );

    mcv_queue #(.WIDTH($bits(t_result)), .DEPTH(RES_DEPTH)) u_res_q (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(w_res_push), .i_wdata(w_res), .o_full(w_res_full),
        .i_pop(pop), .o_rdata(w_res_q), .o_empty(empty)
    );

    assign o_result = t_result'(w_res_q);

    a_res_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res_push |-> !w_res_full)
        else $error("result queue written while full");

    a_cmd_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd_pop |-> !w_cmd_empty)
        else $error("command queue read while empty");

    a_last_on_final_filter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res_push && w_res.last |-> w_res.filter_index == 3'(w_geom.nf - 4'd1))
        else $error("last flag on a filter other than the final one");

endmodule
